### hdl/determinant_excitation_compare_macros.svh
// Assertion helpers, sampled on clk, off while rst_n is low.
`ifndef DETERMINANT_EXCITATION_COMPARE_MACROS_SVH
`define DETERMINANT_EXCITATION_COMPARE_MACROS_SVH

`define DEC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dec assertion failed");

`define DEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dec assertion failed");

`endif

### hdl/dec_pkg.sv
package dec_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ORB_W       = 6;
    localparam int POS_W       = 4;
    localparam int CNT_W       = 5;
    localparam int OCC_W       = 2;
    localparam int LVL_W       = 2;
    localparam int OCFG_W      = 7;

    localparam logic [OCFG_W-1:0] ORB_COUNT_RESET = 7'd10;
    localparam logic [OCC_W-1:0]  OCC_SAT         = 2'd3;
    localparam logic [LVL_W-1:0]  LVL_SAT         = 2'd3;

    localparam logic [1:0] KIND_LEVEL = 2'd0;
    localparam logic [1:0] KIND_REF   = 2'd1;
    localparam logic [1:0] KIND_K     = 2'd2;

    typedef struct packed {
        logic [ORB_W-1:0] r;
        logic [ORB_W-1:0] k;
        logic             rv;
        logic             kv;
        logic [POS_W-1:0] pos;
    } circ_t;

    // sort key: unmarked entries after marked, then orbital, then position
    typedef struct packed {
        logic             unmarked;
        logic [ORB_W-1:0] orb;
        logic [POS_W-1:0] pos;
    } key_t;

    typedef struct packed {
        key_t rkey;
        key_t kkey;
        logic contrib;
        logic occ_err;
    } cell_out_t;

    function automatic logic [OCC_W-1:0] sat_inc(input logic [OCC_W-1:0] c, input logic en);
        logic [OCC_W-1:0] r;
        r = (en && c != OCC_SAT) ? c + OCC_W'(1) : c;
        return r;
    endfunction

endpackage

### hdl/dec_entry_cell.sv
module dec_entry_cell
(
    input  logic                          clk,
    input  logic [dec_pkg::POS_W-1:0]     cell_pos,
    input  logic                          wr,
    input  logic [dec_pkg::ORB_W-1:0]     wr_r,
    input  logic [dec_pkg::ORB_W-1:0]     wr_k,
    input  logic                          wr_rv,
    input  logic                          wr_kv,
    input  logic                          present,
    input  logic                          load,
    input  logic                          shift,
    input  dec_pkg::circ_t                circ_in,
    output dec_pkg::circ_t                circ_out,
    output dec_pkg::cell_out_t            cell_out
);

    logic [dec_pkg::ORB_W-1:0] r_reg;
    logic [dec_pkg::ORB_W-1:0] k_reg;
    logic                      rv_reg;
    logic                      kv_reg;
    dec_pkg::circ_t            circ_reg;
    logic [dec_pkg::OCC_W-1:0] rsa_reg, rsb_reg, rot_reg, ksa_reg, kot_reg;
    logic                      rv_eff, kv_eff;
    logic                      r_mark, k_mark;

    assign rv_eff = present && rv_reg;
    assign kv_eff = present && kv_reg;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            r_reg  <= wr_r;
            k_reg  <= wr_k;
            rv_reg <= wr_rv;
            kv_reg <= wr_kv;
        end
    end

    // ring of entries passes once around; each cell counts matches to its own
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            circ_reg.r   <= r_reg;
            circ_reg.k   <= k_reg;
            circ_reg.rv  <= rv_eff;
            circ_reg.kv  <= kv_eff;
            circ_reg.pos <= cell_pos;
            rsa_reg      <= '0;
            rsb_reg      <= '0;
            rot_reg      <= '0;
            ksa_reg      <= '0;
            kot_reg      <= '0;
        end
        else if (shift)
        begin
            circ_reg <= circ_in;
            rsa_reg  <= dec_pkg::sat_inc(rsa_reg, circ_reg.rv && circ_reg.r == r_reg);
            rsb_reg  <= dec_pkg::sat_inc(rsb_reg, circ_reg.rv && circ_reg.r == r_reg
                                                  && circ_reg.pos < cell_pos);
            rot_reg  <= dec_pkg::sat_inc(rot_reg, circ_reg.kv && circ_reg.k == r_reg);
            ksa_reg  <= dec_pkg::sat_inc(ksa_reg, circ_reg.kv && circ_reg.k == k_reg);
            kot_reg  <= dec_pkg::sat_inc(kot_reg, circ_reg.rv && circ_reg.r == k_reg);
        end
    end

    assign circ_out = circ_reg;

    assign r_mark = rv_eff && rsa_reg > rot_reg;
    assign k_mark = kv_eff && ksa_reg > kot_reg;

    assign cell_out.rkey.unmarked = !r_mark;
    assign cell_out.rkey.orb      = r_reg;
    assign cell_out.rkey.pos      = cell_pos;
    assign cell_out.kkey.unmarked = !k_mark;
    assign cell_out.kkey.orb      = k_reg;
    assign cell_out.kkey.pos      = cell_pos;
    // occurrence number rsb+1 lies in (k count, 3]
    assign cell_out.contrib = rv_eff && rsb_reg != dec_pkg::OCC_SAT && rsb_reg >= rot_reg;
    assign cell_out.occ_err = (rv_eff && rsa_reg == dec_pkg::OCC_SAT)
                           || (kv_eff && ksa_reg == dec_pkg::OCC_SAT);

endmodule

### hdl/dec_sort_cell.sv
module dec_sort_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          ins,
    input  logic          drain,
    input  dec_pkg::key_t key_in,
    input  dec_pkg::key_t prev_key,
    input  logic          prev_valid,
    input  logic          prev_lt,
    input  dec_pkg::key_t next_key,
    input  logic          next_valid,
    output dec_pkg::key_t key,
    output logic          valid,
    output logic          lt
);

    dec_pkg::key_t key_reg;
    logic          valid_reg;

    assign lt = !valid_reg || key_in < key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ins && lt)
        begin
            valid_reg <= prev_lt ? prev_valid : 1'b1;
        end
        else if (drain)
        begin
            valid_reg <= next_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins && lt)
        begin
            key_reg <= prev_lt ? prev_key : key_in;
        end
        else if (drain)
        begin
            key_reg <= next_key;
        end
    end

    assign key   = key_reg;
    assign valid = valid_reg;

endmodule

### hdl/determinant_excitation_compare.sv
// Loading: one pair word per cycle. After the last pair: a setup state (PREP), a
// pass of the ring of entry cells to count occupancies, insertion of the keys
// into the two sorter chains (n pairs), then 1 + 2n result words (only the level
// word when the level saturates), one per cycle while the output does not stall.
// Reset (rst_n, async) empties the set, clears the error flag, orbital_count = 10.
`include "determinant_excitation_compare_macros.svh"

module determinant_excitation_compare
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,   // orbital_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [5:0] ref_orbital, [11:6] k_orbital, zero pad
    input  logic        s_axis_tlast,  // last_pair
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [4:0] value, [5] status, zero pad
    output logic [1:0]  m_axis_tuser,  // [1:0] kind
    output logic        m_axis_tlast   // last_result
);

    localparam int N = dec_pkg::MAX_ENTRIES;

    localparam logic [2:0] ST_LOAD    = 3'd0;
    localparam logic [2:0] ST_PREP    = 3'd1;
    localparam logic [2:0] ST_COUNT   = 3'd2;
    localparam logic [2:0] ST_FEED    = 3'd3;
    localparam logic [2:0] ST_EMIT    = 3'd4;
    localparam logic [2:0] ST_DRAIN_R = 3'd5;
    localparam logic [2:0] ST_DRAIN_K = 3'd6;

    logic [2:0]                  state_reg, state_next;
    logic [dec_pkg::CNT_W-1:0]   pair_count_reg, pair_count_next;
    logic [dec_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        err_reg, err_next;
    logic [dec_pkg::LVL_W-1:0]   lvl_reg, lvl_next;
    logic [dec_pkg::OCFG_W-1:0]  orb_count_reg;

    logic                        out_valid_reg;
    logic [4:0]                  out_value_reg;
    logic                        out_status_reg;
    logic [1:0]                  out_kind_reg;
    logic                        out_last_reg;
    logic                        out_load;
    logic [4:0]                  out_value;
    logic [1:0]                  out_kind;
    logic                        out_last;

    logic                        adv;
    logic                        in_acc;
    logic [dec_pkg::ORB_W-1:0]   in_r, in_k;
    logic                        in_rv, in_kv;
    logic                        wr_en;
    logic                        cell_load, cell_shift;
    logic                        srt_clear, srt_ins, drain_r, drain_k;
    logic [dec_pkg::CNT_W-1:0]   n_minus1;

    dec_pkg::circ_t              circ   [N];
    dec_pkg::cell_out_t          cout   [N];
    logic [N-1:0]                occ_err_v;
    dec_pkg::cell_out_t          feed_sel;

    dec_pkg::key_t               r_key [N];
    logic [N-1:0]                r_valid, r_lt;
    dec_pkg::key_t               k_key [N];
    logic [N-1:0]                k_valid, k_lt;

    assign in_r   = s_axis_tdata[5:0];
    assign in_k   = s_axis_tdata[11:6];
    assign in_rv  = {1'b0, in_r} < orb_count_reg;
    assign in_kv  = {1'b0, in_k} < orb_count_reg;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign adv    = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = state_reg == ST_LOAD;
    assign wr_en  = in_acc && pair_count_reg != dec_pkg::CNT_W'(N);
    assign n_minus1 = pair_count_reg - dec_pkg::CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orb_count_reg <= dec_pkg::ORB_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            orb_count_reg <= cfg_wr_data;
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            dec_entry_cell u_cell
            (
                .clk      (clk),
                .cell_pos (dec_pkg::POS_W'(g)),
                .wr       (wr_en && pair_count_reg[dec_pkg::POS_W-1:0] == dec_pkg::POS_W'(g)),
                .wr_r     (in_r),
                .wr_k     (in_k),
                .wr_rv    (in_rv),
                .wr_kv    (in_kv),
                .present  (dec_pkg::CNT_W'(g) < pair_count_reg),
                .load     (cell_load),
                .shift    (cell_shift),
                .circ_in  (circ[(g + N - 1) % N]),
                .circ_out (circ[g]),
                .cell_out (cout[g])
            );
            assign occ_err_v[g] = cout[g].occ_err;

            dec_sort_cell u_sort_r
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .clear      (srt_clear),
                .ins        (srt_ins),
                .drain      (drain_r),
                .key_in     (feed_sel.rkey),
                .prev_key   (r_key[(g + N - 1) % N]),
                .prev_valid (r_valid[(g + N - 1) % N]),
                .prev_lt    ((g == 0) ? 1'b0 : r_lt[(g + N - 1) % N]),
                .next_key   (r_key[(g + 1) % N]),
                .next_valid ((g == N - 1) ? 1'b0 : r_valid[(g + 1) % N]),
                .key        (r_key[g]),
                .valid      (r_valid[g]),
                .lt         (r_lt[g])
            );

            dec_sort_cell u_sort_k
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .clear      (srt_clear),
                .ins        (srt_ins),
                .drain      (drain_k),
                .key_in     (feed_sel.kkey),
                .prev_key   (k_key[(g + N - 1) % N]),
                .prev_valid (k_valid[(g + N - 1) % N]),
                .prev_lt    ((g == 0) ? 1'b0 : k_lt[(g + N - 1) % N]),
                .next_key   (k_key[(g + 1) % N]),
                .next_valid ((g == N - 1) ? 1'b0 : k_valid[(g + 1) % N]),
                .key        (k_key[g]),
                .valid      (k_valid[g]),
                .lt         (k_lt[g])
            );
        end
    endgenerate

    assign feed_sel = cout[cnt_reg[dec_pkg::POS_W-1:0]];

    always_comb
    begin
        state_next      = state_reg;
        pair_count_next = pair_count_reg;
        cnt_next        = cnt_reg;
        err_next        = err_reg;
        lvl_next        = lvl_reg;
        cell_load       = 1'b0;
        cell_shift      = 1'b0;
        srt_clear       = 1'b0;
        srt_ins         = 1'b0;
        drain_r         = 1'b0;
        drain_k         = 1'b0;
        out_load        = 1'b0;
        out_value       = 5'd0;
        out_kind        = dec_pkg::KIND_LEVEL;
        out_last        = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (wr_en)
                    begin
                        pair_count_next = pair_count_reg + dec_pkg::CNT_W'(1);
                        err_next = err_reg || !in_rv || !in_kv;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                cell_load  = 1'b1;
                srt_clear  = 1'b1;
                lvl_next   = '0;
                cnt_next   = '0;
                state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                cell_shift = 1'b1;
                cnt_next   = cnt_reg + dec_pkg::CNT_W'(1);
                if (cnt_reg == dec_pkg::CNT_W'(N - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                err_next = err_reg || (|occ_err_v);
                if (cnt_reg < pair_count_reg)
                begin
                    srt_ins  = 1'b1;
                    cnt_next = cnt_reg + dec_pkg::CNT_W'(1);
                    lvl_next = (lvl_reg == dec_pkg::LVL_SAT) ? lvl_reg
                             : lvl_reg + dec_pkg::LVL_W'(feed_sel.contrib);
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (adv)
                begin
                    out_load  = 1'b1;
                    out_kind  = dec_pkg::KIND_LEVEL;
                    out_value = {3'd0, lvl_reg};
                    out_last  = lvl_reg == dec_pkg::LVL_SAT || pair_count_reg == '0;
                    if (out_last)
                    begin
                        state_next      = ST_LOAD;
                        pair_count_next = '0;
                        err_next        = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_DRAIN_R;
                    end
                end
            end
            ST_DRAIN_R:
            begin
                if (adv)
                begin
                    out_load  = 1'b1;
                    out_kind  = dec_pkg::KIND_REF;
                    out_value = {1'b0, r_key[0].pos};
                    drain_r   = 1'b1;
                    cnt_next  = cnt_reg + dec_pkg::CNT_W'(1);
                    if (cnt_reg == n_minus1)
                    begin
                        cnt_next   = '0;
                        state_next = ST_DRAIN_K;
                    end
                end
            end
            ST_DRAIN_K:
            begin
                if (adv)
                begin
                    out_load  = 1'b1;
                    out_kind  = dec_pkg::KIND_K;
                    out_value = {1'b0, k_key[0].pos};
                    drain_k   = 1'b1;
                    cnt_next  = cnt_reg + dec_pkg::CNT_W'(1);
                    if (cnt_reg == n_minus1)
                    begin
                        out_last        = 1'b1;
                        cnt_next        = '0;
                        pair_count_next = '0;
                        err_next        = 1'b0;
                        state_next      = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            pair_count_reg <= '0;
            cnt_reg        <= '0;
            err_reg        <= 1'b0;
            lvl_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pair_count_reg <= pair_count_next;
            cnt_reg        <= cnt_next;
            err_reg        <= err_next;
            lvl_reg        <= lvl_next;
            out_valid_reg  <= out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg  <= out_value;
            out_status_reg <= err_reg;
            out_kind_reg   <= out_kind;
            out_last_reg   <= out_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_status_reg, out_value_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    `DEC_ASSERT(a_pair_count_max, pair_count_reg <= dec_pkg::CNT_W'(N))
    `DEC_ASSERT_NEXT(a_count_ends, state_reg == ST_COUNT && cnt_reg == dec_pkg::CNT_W'(N - 1), state_reg == ST_FEED)
    `DEC_ASSERT(a_drain_has_key, state_reg == ST_DRAIN_R |-> r_valid[0])

endmodule
